// ----- src/cpc_pkg.sv -----
// Package for the contact point cache: word types, command codes and the
// fixed slot tables of the eviction area estimate.
// No dependencies.
package cpc_pkg;

    localparam int MAX_POINTS = 4;
    localparam int SLOT_W     = 2;
    localparam int ADDR_W     = 3;

    // Command codes
    localparam logic [1:0] FUNC_ADD     = 2'd0;
    localparam logic [1:0] FUNC_REFRESH = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    localparam logic [2:0]  NO_SLOT    = 3'd4;
    localparam logic [15:0] THR_RESET  = 16'd8;
    // register index, taken from paddr[2]
    localparam logic        REG_THR    = 1'b0;

    typedef struct packed {
        logic [1:0]  func;
        logic [47:0] local_point;
        logic [47:0] world_point_a;
        logic [47:0] world_point_b;
        logic [47:0] contact_normal;
        logic signed [15:0] depth;
    } t_cmd;

    typedef struct packed {
        logic [2:0] point_count;
        logic       stored;
        logic [2:0] replaced_slot;
        logic [2:0] removed_count;
    } t_result;

    typedef struct packed {
        logic [47:0] lp;
        logic [47:0] wa;
        logic [47:0] wb;
        logic [47:0] nm;
        logic [15:0] dp;
    } t_point;

    // Store write controls: new point and slot move
    typedef struct packed {
        logic              new_en;
        logic [SLOT_W-1:0] new_idx;
        logic              mv_en;
        logic [SLOT_W-1:0] mv_src;
        logic [SLOT_W-1:0] mv_dst;
    } t_wr;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_H  = 2'd1,
        SH_H1 = 2'd2,
        SH_2H = 2'd3
    } t_shift;

    // One operation of the shared multiply-accumulate unit
    typedef struct packed {
        logic   go;
        logic   to_sum;
        logic   neg;
        logic   clr_acc;
        logic   clr_sum;
        t_shift sh;
    } t_mop;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_THR  = 6'b000010,
        ST_DUP  = 6'b000100,
        ST_DEEP = 6'b001000,
        ST_AREA = 6'b010000,
        ST_REF  = 6'b100000
    } t_state;

    // Area j: cross of (new - base) and (hi - lo)
    function automatic logic [SLOT_W-1:0] area_base(input logic [SLOT_W-1:0] j);
        area_base = (j == 2'd0) ? 2'd1 : 2'd0;
    endfunction

    function automatic logic [SLOT_W-1:0] area_hi(input logic [SLOT_W-1:0] j);
        area_hi = (j == 2'd3) ? 2'd2 : 2'd3;
    endfunction

    function automatic logic [SLOT_W-1:0] area_lo(input logic [SLOT_W-1:0] j);
        area_lo = (j == 2'd2 || j == 2'd3) ? 2'd1 : 2'd2;
    endfunction

    // Cross component k = a[p]*b[q] - a[q]*b[p]
    function automatic logic [1:0] cross_p(input logic [1:0] k);
        case (k)
            2'd0:    cross_p = 2'd1;
            2'd1:    cross_p = 2'd2;
            default: cross_p = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] cross_q(input logic [1:0] k);
        case (k)
            2'd0:    cross_q = 2'd2;
            2'd1:    cross_q = 2'd0;
            default: cross_q = 2'd1;
        endcase
    endfunction

endpackage

// ----- src/cpc_store.sv -----
// Point store of the contact point cache: four slots in flip-flops,
// one read index, a new-point write and a slot move per cycle.
// Depends on cpc_pkg.
module cpc_store (
    input  logic                         i_clk,
    input  cpc_pkg::t_wr                 i_wr,
    input  cpc_pkg::t_point              i_new,
    input  logic [cpc_pkg::SLOT_W-1:0]   i_rd_idx,
    output cpc_pkg::t_point              o_rd
);

    cpc_pkg::t_point r_slot [cpc_pkg::MAX_POINTS];
    cpc_pkg::t_point n_slot [cpc_pkg::MAX_POINTS];

    // move first, new word wins on the same slot
    always_comb begin
        n_slot = r_slot;
        if (i_wr.mv_en) begin
            n_slot[i_wr.mv_dst] = r_slot[i_wr.mv_src];
        end
        if (i_wr.new_en) begin
            n_slot[i_wr.new_idx] = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_rd = r_slot[i_rd_idx];

endmodule

// ----- src/cpc_mac.sv -----
// Shared multiply-accumulate unit: one unsigned multiplier, a registered
// signed shifted term, and two accumulators (acc and sum).
// Depends on cpc_pkg.
module cpc_mac #(
    parameter int H  = 17,
    parameter int MW = 17,
    parameter int AW = 55,
    parameter int SW = 72
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cpc_pkg::t_mop        i_mop,
    input  logic [MW-1:0]        i_x,
    input  logic [MW-1:0]        i_y,
    output logic signed [AW-1:0] o_acc,
    output logic signed [SW-1:0] o_sum
);

    // aligned product is never narrower than the sum it feeds
    localparam int TW = (2*MW + 2*H + 2 > SW) ? 2*MW + 2*H + 2 : SW;

    logic [2*MW-1:0]      prod;
    logic [TW-1:0]        wide;
    logic signed [SW-1:0] term;
    logic signed [SW-1:0] r_term;
    logic                 r_pend;
    logic                 r_dest;
    logic signed [AW-1:0] r_acc;
    logic signed [SW-1:0] r_sum;

    // multiply and align
    always_comb begin
        prod = i_x * i_y;
        case (i_mop.sh)
            cpc_pkg::SH_0:  wide = TW'(prod);
            cpc_pkg::SH_H:  wide = TW'(prod) << H;
            cpc_pkg::SH_H1: wide = TW'(prod) << (H + 1);
            cpc_pkg::SH_2H: wide = TW'(prod) << (2 * H);
            default:        wide = TW'(prod);
        endcase
        term = i_mop.neg ? -$signed(wide[SW-1:0]) : $signed(wide[SW-1:0]);
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_mop.go;
        end
        r_term <= term;
        r_dest <= i_mop.to_sum;
    end

    // accumulate the registered term in the cycle after issue
    always_ff @(posedge i_clk) begin
        r_acc <= (i_mop.clr_acc ? '0 : r_acc)
               + ((r_pend && !r_dest) ? r_term[AW-1:0] : '0);
        r_sum <= (i_mop.clr_sum ? '0 : r_sum)
               + ((r_pend && r_dest) ? r_term : '0);
    end

    assign o_acc = r_acc;
    assign o_sum = r_sum;

endmodule

// ----- src/contact_point_cache.sv -----
// Contact point cache top level: command sequencer, APB register, result word.
// Add: compares the new point with each stored point; on a full cache, adds the depth
//   scan and an area per slot (none for the deepest slot). Refresh: checks each point,
//   with more work for each point inside the normal window. Clear: empties the cache.
// One word at a time; all products go through one shared multiplier.
// Synchronous active-low reset empties the cache and sets the threshold to 8.
module contact_point_cache #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  cpc_pkg::t_cmd                 i_cmd,
    output logic                          o_done,
    output cpc_pkg::t_result              o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpc_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int C  = COORD_BITS;
    localparam int H  = C + 1;
    localparam int MW = (H > 16) ? H : 16;
    localparam int VW = 2*H + 1;
    localparam int AW = 3*H + 4;
    localparam int SW = 4*H + 4;
    localparam int PW = (3*C > 48) ? 3*C : 48;

    // component k of a packed vector, sign extended
    function automatic logic signed [H-1:0] cx(input logic [47:0] p, input logic [1:0] k);
        logic [PW-1:0]       e;
        logic signed [C-1:0] v;
        e  = PW'(p);
        v  = e[k*C +: C];
        cx = H'(v);
    endfunction

    function automatic logic [MW-1:0] mh(input logic signed [H-1:0] v);
        logic [H-1:0] a;
        a  = v[H-1] ? H'(-v) : H'(v);
        mh = MW'(a);
    endfunction

    function automatic logic [2*H-1:0] mv(input logic signed [VW-1:0] v);
        logic [VW-1:0] a;
        a  = v[VW-1] ? VW'(-v) : VW'(v);
        mv = a[2*H-1:0];
    endfunction

    cpc_pkg::t_state      r_state, n_state;
    logic [3:0]           r_step, n_step;
    logic [1:0]           r_i, n_i;
    logic [1:0]           r_k, n_k;
    logic [2:0]           r_held, n_held;
    logic [15:0]          r_thr;
    logic [31:0]          r_thr2, n_thr2;
    cpc_pkg::t_cmd        r_cmd, n_cmd;
    logic signed [H-1:0]  r_a [3];
    logic signed [H-1:0]  n_a [3];
    logic signed [H-1:0]  r_b [3];
    logic signed [H-1:0]  n_b [3];
    logic signed [VW-1:0] r_val, n_val;
    logic signed [VW-1:0] r_pj, n_pj;
    logic signed [15:0]   r_best, n_best;
    logic [1:0]           r_deep, n_deep;
    logic                 r_deepv, n_deepv;
    logic [SW-1:0]        r_barea, n_barea;
    logic [1:0]           r_victim, n_victim;
    logic [2:0]           r_removed, n_removed;
    logic                 r_done, n_done;
    cpc_pkg::t_result     r_res, n_res;

    cpc_pkg::t_mop        mop;
    logic [MW-1:0]        mul_x, mul_y;
    logic signed [AW-1:0] acc;
    logic signed [SW-1:0] sum;
    cpc_pkg::t_wr         wr;
    cpc_pkg::t_point      new_pt;
    logic [1:0]           rd_idx;
    cpc_pkg::t_point      rd;

    // scratch for the sequencer
    logic                 fin;
    logic                 f_stored;
    logic [2:0]           f_repl;
    logic [1:0]           kk, pp, qq;
    logic                 skip;
    logic [SW-1:0]        area;
    logic [1:0]           vsel;
    logic [2*H-1:0]       sqm;
    logic [2*H-1:0]       dmag;
    logic signed [AW-1:0] thr4;
    logic [2:0]           last;
    logic                 cfg_wr;

    cpc_mac #(.H(H), .MW(MW), .AW(AW), .SW(SW)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mop   (mop),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_acc   (acc),
        .o_sum   (sum)
    );

    assign new_pt = '{lp: r_cmd.local_point, wa: r_cmd.world_point_a,
                      wb: r_cmd.world_point_b, nm: r_cmd.contact_normal,
                      dp: r_cmd.depth};

    cpc_store u_store (
        .i_clk    (i_clk),
        .i_wr     (wr),
        .i_new    (new_pt),
        .i_rd_idx (rd_idx),
        .o_rd     (rd)
    );

    // APB register
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == cpc_pkg::REG_THR);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == cpc_pkg::REG_THR) ? {16'd0, r_thr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= cpc_pkg::THR_RESET;
        end else if (cfg_wr) begin
            r_thr <= pwdata[15:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;  n_step = r_step;  n_i = r_i;  n_k = r_k;
        n_held = r_held;    n_thr2 = r_thr2;  n_cmd = r_cmd;
        n_a = r_a;          n_b = r_b;        n_val = r_val;  n_pj = r_pj;
        n_best = r_best;    n_deep = r_deep;  n_deepv = r_deepv;
        n_barea = r_barea;  n_victim = r_victim;  n_removed = r_removed;
        n_done = 1'b0;      n_res = r_res;
        mop = '0;  mul_x = '0;  mul_y = '0;  wr = '0;  rd_idx = r_i;
        fin = 1'b0;  f_stored = 1'b0;  f_repl = cpc_pkg::NO_SLOT;
        kk = 2'(r_step - 4'd1);
        pp = cpc_pkg::cross_p(r_k);
        qq = cpc_pkg::cross_q(r_k);
        skip = r_deepv && (r_deep == r_i);
        area = '0;  vsel = r_victim;  last = r_held - 3'd1;
        sqm  = (r_state == cpc_pkg::ST_AREA) ? mv(r_val) : mv(r_pj);
        dmag = mv(r_val);
        thr4 = AW'({r_thr2, 4'd0});

        case (r_state)
            cpc_pkg::ST_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_state = cpc_pkg::ST_THR;
                    n_step  = '0;
                end
            end
            // threshold squared, then dispatch
            cpc_pkg::ST_THR: begin
                n_step = r_step + 4'd1;
                if (r_step == 4'd0) begin
                    mop.go = 1'b1;  mop.to_sum = 1'b1;  mop.clr_sum = 1'b1;
                    mul_x = MW'(r_thr);  mul_y = MW'(r_thr);
                end else if (r_step == 4'd2) begin
                    n_thr2 = sum[31:0];
                    n_step = '0;
                    n_removed = '0;
                    case (r_cmd.func)
                        cpc_pkg::FUNC_ADD: begin
                            if (r_held == 3'd0) begin
                                wr.new_en = 1'b1;  wr.new_idx = '0;
                                n_held = 3'd1;
                                fin = 1'b1;  f_stored = 1'b1;
                            end else begin
                                n_state = cpc_pkg::ST_DUP;  n_i = '0;
                            end
                        end
                        cpc_pkg::FUNC_REFRESH: begin
                            if (r_held == 3'd0) begin
                                fin = 1'b1;
                            end else begin
                                n_state = cpc_pkg::ST_REF;  n_i = last[1:0];
                            end
                        end
                        cpc_pkg::FUNC_CLEAR: begin
                            n_removed = r_held;
                            n_held = '0;
                            fin = 1'b1;
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            // duplicate search over stored world points A
            cpc_pkg::ST_DUP: begin
                n_step = r_step + 4'd1;
                if (r_step == 4'd0) begin
                    for (int k = 0; k < 3; k++) begin
                        n_a[k] = cx(rd.wa, 2'(k)) - cx(r_cmd.world_point_a, 2'(k));
                    end
                end else if (r_step <= 4'd3) begin
                    mop.go = 1'b1;  mop.to_sum = 1'b1;
                    mop.clr_sum = (r_step == 4'd1);
                    mul_x = mh(r_a[kk]);  mul_y = mh(r_a[kk]);
                end else if (r_step == 4'd5) begin
                    n_step = '0;
                    if ($unsigned(sum) <= SW'(r_thr2)) begin
                        fin = 1'b1;
                    end else if ({1'b0, r_i} == last) begin
                        if (r_held < 3'(cpc_pkg::MAX_POINTS)) begin
                            wr.new_en = 1'b1;  wr.new_idx = r_held[1:0];
                            n_held = r_held + 3'd1;
                            fin = 1'b1;  f_stored = 1'b1;
                        end else begin
                            n_state = cpc_pkg::ST_DEEP;  n_i = '0;
                            n_best = r_cmd.depth;  n_deepv = 1'b0;
                        end
                    end else begin
                        n_i = r_i + 2'd1;
                    end
                end
            end
            // deepest point, strict greater wins
            cpc_pkg::ST_DEEP: begin
                if ($signed(rd.dp) > r_best) begin
                    n_best = $signed(rd.dp);  n_deep = r_i;  n_deepv = 1'b1;
                end
                n_i = r_i + 2'd1;
                if (r_i == 2'd3) begin
                    n_state = cpc_pkg::ST_AREA;  n_step = '0;
                end
            end
            // squared cross areas and running maximum
            cpc_pkg::ST_AREA: begin
                n_step = r_step + 4'd1;
                case (r_step)
                    4'd0: begin
                        rd_idx = cpc_pkg::area_base(r_i);
                        if (skip) begin
                            n_step = 4'd11;
                        end
                        for (int k = 0; k < 3; k++) begin
                            n_a[k] = cx(r_cmd.local_point, 2'(k)) - cx(rd.lp, 2'(k));
                        end
                    end
                    4'd1: begin
                        rd_idx = cpc_pkg::area_hi(r_i);
                        for (int k = 0; k < 3; k++) begin
                            n_b[k] = cx(rd.lp, 2'(k));
                        end
                    end
                    4'd2: begin
                        rd_idx = cpc_pkg::area_lo(r_i);
                        for (int k = 0; k < 3; k++) begin
                            n_b[k] = r_b[k] - cx(rd.lp, 2'(k));
                        end
                        mop.clr_sum = 1'b1;
                        n_k = '0;
                    end
                    4'd3: begin
                        mop.go = 1'b1;  mop.clr_acc = 1'b1;
                        mop.neg = r_a[pp][H-1] ^ r_b[qq][H-1];
                        mul_x = mh(r_a[pp]);  mul_y = mh(r_b[qq]);
                    end
                    4'd4: begin
                        mop.go = 1'b1;
                        mop.neg = ~(r_a[qq][H-1] ^ r_b[pp][H-1]);
                        mul_x = mh(r_a[qq]);  mul_y = mh(r_b[pp]);
                    end
                    4'd6: n_val = acc[VW-1:0];
                    4'd7: begin
                        mop.go = 1'b1;  mop.to_sum = 1'b1;
                        mul_x = MW'(sqm[H-1:0]);  mul_y = MW'(sqm[H-1:0]);
                    end
                    4'd8: begin
                        mop.go = 1'b1;  mop.to_sum = 1'b1;  mop.sh = cpc_pkg::SH_H1;
                        mul_x = MW'(sqm[2*H-1:H]);  mul_y = MW'(sqm[H-1:0]);
                    end
                    4'd9: begin
                        mop.go = 1'b1;  mop.to_sum = 1'b1;  mop.sh = cpc_pkg::SH_2H;
                        mul_x = MW'(sqm[2*H-1:H]);  mul_y = MW'(sqm[2*H-1:H]);
                        if (r_k != 2'd2) begin
                            n_k = r_k + 2'd1;  n_step = 4'd3;
                        end
                    end
                    4'd11: begin
                        area = skip ? '0 : $unsigned(sum);
                        if (r_i == 2'd0 || r_barea < area) begin
                            n_barea = area;  n_victim = r_i;  vsel = r_i;
                        end
                        n_step = '0;
                        n_i = r_i + 2'd1;
                        if (r_i == 2'd3) begin
                            wr.mv_en  = (vsel != 2'd3);
                            wr.mv_src = 2'd3;  wr.mv_dst = vsel;
                            wr.new_en = 1'b1;  wr.new_idx = 2'd3;
                            fin = 1'b1;  f_stored = 1'b1;  f_repl = {1'b0, vsel};
                        end
                    end
                    default: ;
                endcase
            end
            // refresh from the top slot down
            cpc_pkg::ST_REF: begin
                n_step = r_step + 4'd1;
                case (r_step)
                    4'd0: begin
                        mop.clr_acc = 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            n_a[k] = cx(rd.wa, 2'(k)) - cx(rd.wb, 2'(k));
                            n_b[k] = cx(rd.nm, 2'(k));
                        end
                    end
                    4'd1, 4'd2, 4'd3: begin
                        mop.go = 1'b1;
                        mop.neg = r_a[kk][H-1] ^ r_b[kk][H-1];
                        mul_x = mh(r_a[kk]);  mul_y = mh(r_b[kk]);
                    end
                    4'd5: begin
                        if (acc > thr4) begin
                            n_step = '0;
                            if (r_i == 2'd0) begin
                                fin = 1'b1;
                            end else begin
                                n_i = r_i - 2'd1;
                            end
                        end else begin
                            n_val = VW'(acc >>> 12);
                            n_k = '0;
                            mop.clr_sum = 1'b1;
                        end
                    end
                    4'd6: begin
                        mop.go = 1'b1;  mop.clr_acc = 1'b1;
                        mop.neg = r_b[r_k][H-1] ^ r_val[VW-1];
                        mul_x = mh(r_b[r_k]);  mul_y = MW'(dmag[H-1:0]);
                    end
                    4'd7: begin
                        mop.go = 1'b1;  mop.sh = cpc_pkg::SH_H;
                        mop.neg = r_b[r_k][H-1] ^ r_val[VW-1];
                        mul_x = mh(r_b[r_k]);  mul_y = MW'(dmag[2*H-1:H]);
                    end
                    4'd9: n_pj = VW'(-r_a[r_k]) + VW'(acc >>> 12);
                    4'd10: begin
                        mop.go = 1'b1;  mop.to_sum = 1'b1;
                        mul_x = MW'(sqm[H-1:0]);  mul_y = MW'(sqm[H-1:0]);
                    end
                    4'd11: begin
                        mop.go = 1'b1;  mop.to_sum = 1'b1;  mop.sh = cpc_pkg::SH_H1;
                        mul_x = MW'(sqm[2*H-1:H]);  mul_y = MW'(sqm[H-1:0]);
                    end
                    4'd12: begin
                        mop.go = 1'b1;  mop.to_sum = 1'b1;  mop.sh = cpc_pkg::SH_2H;
                        mul_x = MW'(sqm[2*H-1:H]);  mul_y = MW'(sqm[2*H-1:H]);
                        if (r_k != 2'd2) begin
                            n_k = r_k + 2'd1;  n_step = 4'd6;
                        end
                    end
                    4'd14: begin
                        if ($unsigned(sum) > SW'(r_thr2)) begin
                            wr.mv_en  = ({1'b0, r_i} < last);
                            wr.mv_src = last[1:0];  wr.mv_dst = r_i;
                            n_held    = last;
                            n_removed = r_removed + 3'd1;
                        end
                        n_step = '0;
                        if (r_i == 2'd0) begin
                            fin = 1'b1;
                        end else begin
                            n_i = r_i - 2'd1;
                        end
                    end
                    default: ;
                endcase
            end
            default: n_state = cpc_pkg::ST_IDLE;
        endcase

        // result word
        if (fin) begin
            n_state = cpc_pkg::ST_IDLE;
            n_done  = 1'b1;
            n_res.point_count   = n_held;
            n_res.stored        = f_stored;
            n_res.replaced_slot = f_repl;
            n_res.removed_count = (r_cmd.func == cpc_pkg::FUNC_ADD) ? 3'd0 : n_removed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpc_pkg::ST_IDLE;
            r_held  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_done  <= n_done;
        end
        r_step    <= n_step;    r_i      <= n_i;      r_k <= n_k;
        r_thr2    <= n_thr2;    r_cmd    <= n_cmd;
        r_a       <= n_a;       r_b      <= n_b;
        r_val     <= n_val;     r_pj     <= n_pj;
        r_best    <= n_best;    r_deep   <= n_deep;   r_deepv <= n_deepv;
        r_barea   <= n_barea;   r_victim <= n_victim;
        r_removed <= n_removed; r_res    <= n_res;
    end

    assign busy     = (r_state != cpc_pkg::ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ----- src/cpc_check.sv -----
// Port checker for the contact point cache, bound to the top level.
// Depends on cpc_pkg and contact_point_cache.
module cpc_check (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input cpc_pkg::t_result o_result
);

    // a result closes a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result word without a preceding command");

    // an accepted command makes the block busy
    a_busy_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("command accepted but block not busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.point_count <= 3'd4)
        else $error("point count out of range");

    // a dropped or non-add word evicts nothing
    a_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.stored |-> o_result.replaced_slot == cpc_pkg::NO_SLOT)
        else $error("eviction reported without a stored point");

    a_add_no_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.stored |-> o_result.removed_count == 3'd0)
        else $error("add reported removed points");

endmodule

bind contact_point_cache cpc_check u_cpc_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
